### hdl/bankers_safety_check_assert.svh
// Assertion macros for the safety check block.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef BANKERS_SAFETY_CHECK_ASSERT_SVH
`define BANKERS_SAFETY_CHECK_ASSERT_SVH

// ante implies cons on the same edge
`define BSC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsc: implication check failed");

// sig keeps its value in the cycle after a stalled beat
`define BSC_ASSERT_HOLD(label, vld, rdy, sig) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> $stable(sig)) \
		else $error("bsc: stalled beat changed");

`endif

### hdl/bsc_pkg.sv
// Shared types and constants of the safety check block.
// No dependencies; used by the interfaces, the store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

	localparam int MAX_PROCESSES_DEF = 16;
	localparam int MAX_RESOURCES_DEF = 8;
	localparam int AMOUNT_WIDTH_DEF  = 16;

	localparam int PID_W      = 4;
	localparam int RID_W      = 3;
	localparam int AMT_W      = 16;
	localparam int PCNT_W     = 5;
	localparam int RCNT_W     = 4;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [PCNT_W-1:0] PCNT_RST = 5'd16;
	localparam logic [RCNT_W-1:0] RCNT_RST = 4'd8;

	typedef enum logic [1:0] {
		CMD_LOAD_ALLOC = 2'd0,
		CMD_LOAD_MAX   = 2'd1,
		CMD_LOAD_AVAIL = 2'd2,
		CMD_RUN        = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_COUNT  = 8'd0,
		REG_RESOURCE_COUNT = 8'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COPY,
		S_SCAN,
		S_CHECK,
		S_DECIDE,
		S_ADD,
		S_PUSH,
		S_FINAL
	} state_t;

	typedef enum logic [1:0] {
		OP_COPY,
		OP_CHECK,
		OP_ADD
	} op_t;

	typedef struct packed {
		logic alloc_we;
		logic max_we;
		logic avail_we;
	} store_we_t;

endpackage

`default_nettype wire

### hdl/bsc_ifs.sv
// Channel interfaces of the safety check block: command, result, register write.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bsc_req_if;
	logic                           valid;
	logic                           ready;
	bsc_pkg::cmd_t                  cmd;
	logic [bsc_pkg::PID_W-1:0]      process_index;
	logic [bsc_pkg::RID_W-1:0]      resource_index;
	logic [bsc_pkg::AMT_W-1:0]      amount;

	modport source (output valid, cmd, process_index, resource_index, amount, input ready);
	modport sink (input valid, cmd, process_index, resource_index, amount, output ready);
endinterface

interface bsc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [bsc_pkg::PID_W-1:0]      process_id;
	logic                           process_valid;
	logic                           last;
	logic                           safe;

	modport source (output valid, process_id, process_valid, last, safe, input ready);
	modport sink (input valid, process_id, process_valid, last, safe, output ready);
endinterface

interface bsc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bsc_pkg::CFG_IDX_W-1:0]  index;
	logic [bsc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/bankers_safety_check.sv
// Banker's safety check. Loads are accepted while idle; a run copies the available
// vector into the work vector, then makes n passes over the processes, skipping
// finished ones; a process that passes its check is marked and adds its allocation.
// One item at a time: the check/add sweep reads one resource per cycle from the stores.
// Reset clears control, work vector and finished marks; process_count=16, resource_count=8.
// Allocation, max-claim and available stores are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module bankers_safety_check #(
	parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
	parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
	parameter int AMOUNT_WIDTH  = bsc_pkg::AMOUNT_WIDTH_DEF
) (
	input wire         clk,
	input wire         arst_n,
	bsc_cfg_if.sink    cfg,
	bsc_req_if.sink    req,
	bsc_rsp_if.source  rsp
);

	localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
	localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PIW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
	localparam int CW    = $clog2(MAX_PROCESSES + 1);
	localparam int RCW   = $clog2(MAX_RESOURCES + 1);
	localparam int WW    = AMOUNT_WIDTH + CW;
	localparam int CMPW  = WW + 1;

	typedef struct packed {
		logic         issue;
		bsc_pkg::op_t op;
		logic         r_inc;
		logic         r_clr;
		logic         p_adv;
		logic         clr_fail;
		logic         mark;
		logic         push;
		logic         push_last;
		logic         pend_load;
		logic         run_start;
	} run_ctl_t;

	bsc_pkg::state_t            state_q, state_d;
	run_ctl_t                   ctl;

	logic [bsc_pkg::PCNT_W-1:0] pcnt_q;
	logic [bsc_pkg::RCNT_W-1:0] rcnt_q;
	logic [CW-1:0]              n_c, n_q;
	logic [RCW-1:0]             m_c, m_q;
	logic [PIW-1:0]             p_q;
	logic [CW-1:0]              pass_q;
	logic [RIW-1:0]             r_q;
	logic                       fail_q;
	logic [MAX_PROCESSES-1:0]   fin_q;
	logic [CW-1:0]              cnt_q;
	logic [PIW-1:0]             pend_id_q;
	logic                       pend_vld_q;
	logic [WW-1:0]              work_q [MAX_RESOURCES];

	logic                       vld_s1;
	bsc_pkg::op_t               op_s1;
	logic [RIW-1:0]             r_s1;

	logic                       rsp_valid_q;
	logic [bsc_pkg::PID_W-1:0]  rsp_id_q;
	logic                       rsp_pvld_q;
	logic                       rsp_last_q;
	logic                       rsp_safe_q;

	logic                       req_acc;
	logic                       p_ok, r_ok;
	logic [AMOUNT_WIDTH-1:0]    ld_amount;
	logic [MAW-1:0]             wr_mat_addr, rd_mat_addr;
	bsc_pkg::store_we_t         we;
	logic [AMOUNT_WIDTH-1:0]    alloc_rd, max_rd, avail_rd;
	logic [WW-1:0]              work_rd;
	logic                       chk_fail, fail_now;
	logic                       r_last, p_last, out_free;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= bsc_pkg::PCNT_RST;
			rcnt_q <= bsc_pkg::RCNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bsc_pkg::REG_PROCESS_COUNT:  pcnt_q <= cfg.data[bsc_pkg::PCNT_W-1:0];
				bsc_pkg::REG_RESOURCE_COUNT: rcnt_q <= cfg.data[bsc_pkg::RCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_c = (pcnt_q == '0) ? CW'(1) :
	             (32'(pcnt_q) > MAX_PROCESSES) ? CW'(MAX_PROCESSES) : CW'(pcnt_q);
	assign m_c = (rcnt_q == '0) ? RCW'(1) :
	             (32'(rcnt_q) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(rcnt_q);

	// loads
	assign req_acc   = req.valid && req.ready;
	assign p_ok      = 32'(req.process_index) < MAX_PROCESSES;
	assign r_ok      = 32'(req.resource_index) < MAX_RESOURCES;
	assign ld_amount = AMOUNT_WIDTH'(req.amount);
	assign wr_mat_addr = MAW'(MAW'(req.process_index) * MAW'(MAX_RESOURCES)
	                   + MAW'(req.resource_index));
	assign rd_mat_addr = MAW'(MAW'(p_q) * MAW'(MAX_RESOURCES) + MAW'(r_q));

	always_comb begin
		we.alloc_we = req_acc && (req.cmd == bsc_pkg::CMD_LOAD_ALLOC) && p_ok && r_ok;
		we.max_we   = req_acc && (req.cmd == bsc_pkg::CMD_LOAD_MAX) && p_ok && r_ok;
		we.avail_we = req_acc && (req.cmd == bsc_pkg::CMD_LOAD_AVAIL) && r_ok;
	end

	bsc_store #(
		.MAX_PROCESSES (MAX_PROCESSES),
		.MAX_RESOURCES (MAX_RESOURCES),
		.AMOUNT_WIDTH  (AMOUNT_WIDTH)
	) u_store (
		.clk           (clk),
		.we            (we),
		.wr_mat_addr   (wr_mat_addr),
		.wr_avail_addr (RIW'(req.resource_index)),
		.wr_data       (ld_amount),
		.rd_mat_addr   (rd_mat_addr),
		.rd_avail_addr (r_q),
		.alloc_rd      (alloc_rd),
		.max_rd        (max_rd),
		.avail_rd      (avail_rd)
	);

	// sweep compare: need > work  <=>  max > alloc + work
	assign work_rd  = work_q[r_s1];
	assign chk_fail = CMPW'(max_rd) > (CMPW'(alloc_rd) + CMPW'(work_rd));
	assign fail_now = fail_q || (vld_s1 && (op_s1 == bsc_pkg::OP_CHECK) && chk_fail);

	assign r_last   = (RCW'(r_q) + RCW'(1)) == m_q;
	assign p_last   = (CW'(p_q) + CW'(1)) == n_q;
	assign out_free = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		ctl.op    = bsc_pkg::OP_COPY;
		req.ready = 1'b0;
		unique case (state_q)
			bsc_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && (req.cmd == bsc_pkg::CMD_RUN)) begin
					ctl.run_start = 1'b1;
					state_d       = bsc_pkg::S_COPY;
				end
			end
			bsc_pkg::S_COPY: begin
				ctl.issue = 1'b1;
				ctl.op    = bsc_pkg::OP_COPY;
				if (r_last) begin
					ctl.r_clr = 1'b1;
					state_d   = bsc_pkg::S_SCAN;
				end else begin
					ctl.r_inc = 1'b1;
				end
			end
			bsc_pkg::S_SCAN: begin
				if (pass_q == n_q) begin
					state_d = bsc_pkg::S_FINAL;
				end else if (fin_q[p_q]) begin
					ctl.p_adv = 1'b1;
				end else begin
					ctl.clr_fail = 1'b1;
					state_d      = bsc_pkg::S_CHECK;
				end
			end
			bsc_pkg::S_CHECK: begin
				ctl.issue = 1'b1;
				ctl.op    = bsc_pkg::OP_CHECK;
				if (r_last) begin
					ctl.r_clr = 1'b1;
					state_d   = bsc_pkg::S_DECIDE;
				end else begin
					ctl.r_inc = 1'b1;
				end
			end
			bsc_pkg::S_DECIDE: begin
				if (fail_now) begin
					ctl.p_adv = 1'b1;
					state_d   = bsc_pkg::S_SCAN;
				end else begin
					ctl.mark = 1'b1;
					state_d  = bsc_pkg::S_ADD;
				end
			end
			bsc_pkg::S_ADD: begin
				ctl.issue = 1'b1;
				ctl.op    = bsc_pkg::OP_ADD;
				if (r_last) begin
					ctl.r_clr = 1'b1;
					state_d   = bsc_pkg::S_PUSH;
				end else begin
					ctl.r_inc = 1'b1;
				end
			end
			bsc_pkg::S_PUSH: begin
				if (!pend_vld_q || out_free) begin
					ctl.push      = pend_vld_q;
					ctl.pend_load = 1'b1;
					ctl.p_adv     = 1'b1;
					state_d       = bsc_pkg::S_SCAN;
				end
			end
			bsc_pkg::S_FINAL: begin
				if (out_free) begin
					ctl.push      = 1'b1;
					ctl.push_last = 1'b1;
					state_d       = bsc_pkg::S_IDLE;
				end
			end
			default: state_d = bsc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= '0;
			m_q        <= '0;
			p_q        <= '0;
			pass_q     <= '0;
			r_q        <= '0;
			fail_q     <= 1'b0;
			fin_q      <= '0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			fail_q <= ctl.clr_fail ? 1'b0 : fail_now;
			if (ctl.run_start) begin
				n_q        <= n_c;
				m_q        <= m_c;
				p_q        <= '0;
				pass_q     <= '0;
				r_q        <= '0;
				fin_q      <= '0;
				cnt_q      <= '0;
				pend_vld_q <= 1'b0;
			end
			if (ctl.r_clr) begin
				r_q <= '0;
			end else if (ctl.r_inc) begin
				r_q <= r_q + RIW'(1);
			end
			if (ctl.p_adv) begin
				if (p_last) begin
					p_q    <= '0;
					pass_q <= pass_q + CW'(1);
				end else begin
					p_q <= p_q + PIW'(1);
				end
			end
			if (ctl.mark) begin
				fin_q[p_q] <= 1'b1;
				cnt_q      <= cnt_q + CW'(1);
			end
			if (ctl.pend_load) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= ctl.op;
		r_s1  <= r_q;
		if (ctl.pend_load) begin
			pend_id_q <= p_q;
		end
	end

	// work vector read-modify-write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				work_q[i] <= '0;
			end
		end else if (vld_s1) begin
			unique case (op_s1)
				bsc_pkg::OP_COPY: work_q[r_s1] <= WW'(avail_rd);
				bsc_pkg::OP_ADD:  work_q[r_s1] <= work_rd + WW'(alloc_rd);
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			rsp_id_q   <= pend_vld_q ? bsc_pkg::PID_W'(pend_id_q) : '0;
			rsp_pvld_q <= pend_vld_q;
			rsp_last_q <= ctl.push_last;
			rsp_safe_q <= ctl.push_last && pend_vld_q && (cnt_q == n_q);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.process_id    = rsp_id_q;
	assign rsp.process_valid = rsp_pvld_q;
	assign rsp.last          = rsp_last_q;
	assign rsp.safe          = rsp_safe_q;

endmodule

`default_nettype wire

### hdl/bsc_store.sv
// Allocation/maximum-claim matrix memory and available memory, registered read.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_store #(
	parameter int MAX_PROCESSES = bsc_pkg::MAX_PROCESSES_DEF,
	parameter int MAX_RESOURCES = bsc_pkg::MAX_RESOURCES_DEF,
	parameter int AMOUNT_WIDTH  = bsc_pkg::AMOUNT_WIDTH_DEF,
	localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES,
	localparam int MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
) (
	input  wire                     clk,
	input  wire bsc_pkg::store_we_t we,
	input  wire  [MAW-1:0]          wr_mat_addr,
	input  wire  [RIW-1:0]          wr_avail_addr,
	input  wire  [AMOUNT_WIDTH-1:0] wr_data,
	input  wire  [MAW-1:0]          rd_mat_addr,
	input  wire  [RIW-1:0]          rd_avail_addr,
	output logic [AMOUNT_WIDTH-1:0] alloc_rd,
	output logic [AMOUNT_WIDTH-1:0] max_rd,
	output logic [AMOUNT_WIDTH-1:0] avail_rd
);

	logic [2*AMOUNT_WIDTH-1:0] mat_mem   [DEPTH];
	logic [AMOUNT_WIDTH-1:0]   avail_mem [MAX_RESOURCES];
	logic [2*AMOUNT_WIDTH-1:0] mat_rd;

	// low half: allocation, high half: max claim
	always_ff @(posedge clk) begin
		if (we.alloc_we) begin
			mat_mem[wr_mat_addr][AMOUNT_WIDTH-1:0] <= wr_data;
		end
		if (we.max_we) begin
			mat_mem[wr_mat_addr][2*AMOUNT_WIDTH-1:AMOUNT_WIDTH] <= wr_data;
		end
		mat_rd <= mat_mem[rd_mat_addr];
	end

	assign alloc_rd = mat_rd[AMOUNT_WIDTH-1:0];
	assign max_rd   = mat_rd[2*AMOUNT_WIDTH-1:AMOUNT_WIDTH];

	always_ff @(posedge clk) begin
		if (we.avail_we) begin
			avail_mem[wr_avail_addr] <= wr_data;
		end
		avail_rd <= avail_mem[rd_avail_addr];
	end

endmodule

`default_nettype wire

### hdl/bsc_checker.sv
// Port-level checks on the result channel of the safety check block.
// Depends on bankers_safety_check_assert.svh; bound to bankers_safety_check.
`timescale 1ns / 1ps
`default_nettype none

`include "bankers_safety_check_assert.svh"

module bsc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            rsp_valid,
	input wire                            rsp_ready,
	input wire [bsc_pkg::PID_W-1:0]       process_id,
	input wire                            process_valid,
	input wire                            last,
	input wire                            safe
);

	`BSC_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, {rsp_valid, process_id, process_valid, last, safe})
	`BSC_ASSERT_IMPLY(a_mid_beat, rsp_valid && !last, process_valid && !safe)
	`BSC_ASSERT_IMPLY(a_safe_final, rsp_valid && safe, last && process_valid)
	`BSC_ASSERT_IMPLY(a_none_done, rsp_valid && !process_valid, last && !safe && (process_id == '0))

endmodule

bind bankers_safety_check bsc_checker u_bsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.process_id    (rsp.process_id),
	.process_valid (rsp.process_valid),
	.last          (rsp.last),
	.safe          (rsp.safe)
);

`default_nettype wire

### dv/bsc_sequence_checker.sv
// Scoreboard for the safety check block: watches the register, command and result channels.
// Keeps its own stores and counts, predicts each run's safe sequence and compares results.
// Depends on bsc_pkg and the channel interfaces in bsc_ifs.
`timescale 1ns / 1ps

module bsc_sequence_checker (
	input wire clk,
	input wire arst_n,
	bsc_cfg_if cfg,
	bsc_req_if req,
	bsc_rsp_if rsp,
	output int fail_count,
	output int outstanding
);

	localparam int PID_W  = bsc_pkg::PID_W;
	localparam int AMT_W  = bsc_pkg::AMT_W;
	localparam int PCNT_W = bsc_pkg::PCNT_W;
	localparam int RCNT_W = bsc_pkg::RCNT_W;
	localparam int NPROC  = bsc_pkg::MAX_PROCESSES_DEF;
	localparam int NRES   = bsc_pkg::MAX_RESOURCES_DEF;

	typedef struct packed {
		logic [PID_W-1:0] process_id;
		logic             process_valid;
		logic             last;
		logic             safe;
	} grant_t;

	logic [AMT_W-1:0] alloc_units [NPROC][NRES];
	logic [AMT_W-1:0] claim_units [NPROC][NRES];
	logic [AMT_W-1:0] avail_units [NRES];
	logic [PCNT_W-1:0] proc_reg = bsc_pkg::PCNT_RST;
	logic [RCNT_W-1:0] res_reg = bsc_pkg::RCNT_RST;
	grant_t grant_q [$];
	grant_t want;

	task automatic report(string what);
		fail_count++;
		$display("[%0t] bsc: %s", $time, what);
	endtask

	task automatic predict_sequence();
		int n, m, k, fin;
		longint work [NRES];
		bit done [NPROC];
		bit fits;
		grant_t g;
		n = (proc_reg == '0) ? 1 :
			(int'(proc_reg) > NPROC) ? NPROC : int'(proc_reg);
		m = (res_reg == '0) ? 1 :
			(int'(res_reg) > NRES) ? NRES : int'(res_reg);
		k = 0;
		fin = 0;
		foreach (work[r]) work[r] = longint'(avail_units[r]);
		foreach (done[p]) done[p] = 1'b0;
		for (int pass = 0; pass < n; pass++) begin
			for (int p = 0; p < n; p++) begin
				if (done[p]) continue;
				fits = 1'b1;
				for (int r = 0; r < m; r++) begin
					if (longint'(claim_units[p][r]) - longint'(alloc_units[p][r]) > work[r])
						fits = 1'b0;
				end
				if (!fits) continue;
				for (int r = 0; r < m; r++) work[r] += longint'(alloc_units[p][r]);
				done[p] = 1'b1;
				fin++;
				g.process_id = PID_W'(p);
				g.process_valid = 1'b1;
				g.last = 1'b0;
				g.safe = 1'b0;
				grant_q.push_back(g);
				k++;
			end
		end
		if (k == 0) begin
			g.process_id = '0;
			g.process_valid = 1'b0;
			g.last = 1'b1;
			g.safe = 1'b0;
			grant_q.push_back(g);
		end else begin
			grant_q[grant_q.size()-1].last = 1'b1;
			grant_q[grant_q.size()-1].safe = (fin == n);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_q.delete();
			proc_reg = bsc_pkg::PCNT_RST;
			res_reg = bsc_pkg::RCNT_RST;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (grant_q.size() == 0) begin
					report($sformatf("result with nothing pending: id=%0d valid=%0b last=%0b safe=%0b",
						rsp.process_id, rsp.process_valid, rsp.last, rsp.safe));
				end else begin
					want = grant_q.pop_front();
					if (rsp.process_id !== want.process_id ||
						rsp.process_valid !== want.process_valid ||
						rsp.last !== want.last || rsp.safe !== want.safe)
						report($sformatf({"result id=%0d valid=%0b last=%0b safe=%0b, ",
							"want id=%0d valid=%0b last=%0b safe=%0b"},
							rsp.process_id, rsp.process_valid, rsp.last, rsp.safe,
							want.process_id, want.process_valid, want.last, want.safe));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					bsc_pkg::REG_PROCESS_COUNT: proc_reg = cfg.data[PCNT_W-1:0];
					bsc_pkg::REG_RESOURCE_COUNT: res_reg = cfg.data[RCNT_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				case (req.cmd)
					bsc_pkg::CMD_LOAD_ALLOC:
						alloc_units[req.process_index][req.resource_index] = req.amount;
					bsc_pkg::CMD_LOAD_MAX:
						claim_units[req.process_index][req.resource_index] = req.amount;
					bsc_pkg::CMD_LOAD_AVAIL: avail_units[req.resource_index] = req.amount;
					bsc_pkg::CMD_RUN: predict_sequence();
					default: ;
				endcase
			end
			outstanding <= grant_q.size();
		end
	end

endmodule

### dv/tb.sv
// Top of the safety check testbench: clock, reset, stimulus, result-side stalls and verdict.
// Instantiates bankers_safety_check beside bsc_sequence_checker; needs bsc_pkg and bsc_ifs.
`timescale 1ns / 1ps

module tb;

	localparam int PID_W = bsc_pkg::PID_W;
	localparam int RID_W = bsc_pkg::RID_W;
	localparam int AMT_W = bsc_pkg::AMT_W;
	localparam int PCNT_W = bsc_pkg::PCNT_W;
	localparam int RCNT_W = bsc_pkg::RCNT_W;
	localparam int CFG_DATA_W = bsc_pkg::CFG_DATA_W;
	localparam int NPROC = bsc_pkg::MAX_PROCESSES_DEF;
	localparam int NRES = bsc_pkg::MAX_RESOURCES_DEF;

	localparam int QUIET_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit idle_on = 1'b1;
	int press_req = 0;
	int press_seen = 0;
	int quiet = 0;
	int fail_count;
	int outstanding;
	int cur_n = 16;
	int cur_m = 8;
	int random_items = 0;
	int sel;
	logic [CFG_DATA_W-1:0] pd, rd;

	bsc_cfg_if cfg_ch();
	bsc_req_if req_ch();
	bsc_rsp_if rsp_ch();

	bankers_safety_check i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	bsc_sequence_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (press_seen != press_req) begin
				press_seen = press_req;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 30)) @(posedge clk);
			end
		end
	end

	task automatic send_item(bsc_pkg::cmd_t c, logic [PID_W-1:0] p, logic [RID_W-1:0] r,
		logic [AMT_W-1:0] a);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.process_index <= p;
		req_ch.resource_index <= r;
		req_ch.amount <= a;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic send_run();
		send_item(bsc_pkg::CMD_RUN, PID_W'($urandom), RID_W'($urandom), AMT_W'($urandom));
	endtask

	task automatic send_random_load();
		bsc_pkg::cmd_t c;
		logic [AMT_W-1:0] a;
		case ($urandom_range(0, 2))
			0: begin
				c = bsc_pkg::CMD_LOAD_ALLOC;
				a = AMT_W'($urandom_range(0, 6));
			end
			1: begin
				c = bsc_pkg::CMD_LOAD_MAX;
				a = AMT_W'($urandom_range(0, 12));
			end
			default: begin
				c = bsc_pkg::CMD_LOAD_AVAIL;
				a = AMT_W'($urandom_range(0, 15));
			end
		endcase
		if ($urandom_range(0, 9) == 0)
			send_item(c, PID_W'($urandom), RID_W'($urandom), AMT_W'($urandom));
		else
			send_item(c, PID_W'($urandom_range(0, cur_n - 1)),
				RID_W'($urandom_range(0, cur_m - 1)), a);
	endtask

	// drop valid, drain pending results, then let the block go quiet
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_counts(logic [CFG_DATA_W-1:0] pv, logic [CFG_DATA_W-1:0] rv);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= bsc_pkg::REG_PROCESS_COUNT;
		cfg_ch.data <= pv;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= bsc_pkg::REG_RESOURCE_COUNT;
		cfg_ch.data <= rv;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_n = (pv[PCNT_W-1:0] == '0) ? 1 :
			(int'(pv[PCNT_W-1:0]) > NPROC) ? NPROC : int'(pv[PCNT_W-1:0]);
		cur_m = (rv[RCNT_W-1:0] == '0) ? 1 :
			(int'(rv[RCNT_W-1:0]) > NRES) ? NRES : int'(rv[RCNT_W-1:0]);
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.cmd = bsc_pkg::CMD_LOAD_ALLOC;
		req_ch.process_index = '0;
		req_ch.resource_index = '0;
		req_ch.amount = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = bsc_pkg::REG_PROCESS_COUNT;
		cfg_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill resource 0 of every process and all resources of processes 0 and 1;
		// every run below stays inside that region
		set_counts(8'd16, 8'd1);
		for (int r = 0; r < NRES; r++)
			send_item(bsc_pkg::CMD_LOAD_AVAIL, PID_W'($urandom), RID_W'(r),
				AMT_W'($urandom_range(0, 15)));
		for (int p = 0; p < NPROC; p++) begin
			for (int r = 0; r < ((p < 2) ? NRES : 1); r++) begin
				send_item(bsc_pkg::CMD_LOAD_ALLOC, PID_W'(p), RID_W'(r),
					AMT_W'($urandom_range(0, 6)));
				send_item(bsc_pkg::CMD_LOAD_MAX, PID_W'(p), RID_W'(r),
					AMT_W'($urandom_range(0, 12)));
			end
		end
		send_run();
		settle();
		set_counts(8'd2, 8'd8);
		send_run();

		settle();
		set_counts(8'd2, 8'd2);
		send_item(bsc_pkg::CMD_LOAD_AVAIL, 4'd9, 3'd0, 16'd0);
		send_item(bsc_pkg::CMD_LOAD_AVAIL, 4'd0, 3'd1, 16'd0);
		send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd0, 3'd0, 16'd0);
		send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd0, 3'd1, 16'd0);
		send_item(bsc_pkg::CMD_LOAD_MAX, 4'd0, 3'd0, 16'hFFFF);
		send_item(bsc_pkg::CMD_LOAD_MAX, 4'd0, 3'd1, 16'hFFFF);
		send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd1, 3'd0, 16'hFFFF);
		send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd1, 3'd1, 16'd0);
		send_item(bsc_pkg::CMD_LOAD_MAX, 4'd1, 3'd0, 16'd0);
		send_item(bsc_pkg::CMD_LOAD_MAX, 4'd1, 3'd1, 16'd0);
		send_run();
		send_item(bsc_pkg::CMD_LOAD_MAX, 4'd0, 3'd1, 16'd0);
		send_run();
		send_item(bsc_pkg::CMD_LOAD_MAX, 4'd1, 3'd0, 16'hFFFF);
		send_item(bsc_pkg::CMD_LOAD_ALLOC, 4'd1, 3'd0, 16'd0);
		send_run();

		settle();
		set_counts(8'd1, 8'd1);
		send_random_load();
		send_run();
		settle();
		set_counts(8'd0, 8'd0);
		send_run();
		settle();
		set_counts(8'hFF, 8'hF1);
		send_run();
		settle();
		set_counts(8'hE2, 8'hFF);
		send_run();

		// hold the result side while a full safe run and more loads queue up
		settle();
		set_counts(8'd16, 8'd1);
		press_req++;
		do @(posedge clk); while (press_seen != press_req);
		send_item(bsc_pkg::CMD_LOAD_AVAIL, PID_W'($urandom), 3'd0, 16'hFFFF);
		send_run();
		repeat (3) send_random_load();
		send_run();

		while (random_items < RANDOM_ITEMS) begin
			settle();
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				pd = CFG_DATA_W'($urandom);
				rd = {4'($urandom), 4'd1};
			end else if (sel == 1) begin
				pd = {3'($urandom), 5'd2};
				rd = CFG_DATA_W'($urandom);
			end else if (sel < 6) begin
				pd = CFG_DATA_W'($urandom_range(1, 16));
				rd = 8'd1;
			end else begin
				pd = CFG_DATA_W'($urandom_range(1, 2));
				rd = CFG_DATA_W'($urandom_range(1, 8));
			end
			set_counts(pd, rd);
			repeat ($urandom_range(1, 3)) begin
				if (random_items >= RANDOM_ITEMS - 8) idle_on = 1'b0;
				repeat ($urandom_range(0, 4)) begin
					send_random_load();
					random_items++;
				end
				send_run();
				random_items++;
			end
		end

		settle();
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### bankers_safety_check.f
+incdir+hdl
hdl/bsc_pkg.sv
hdl/bsc_ifs.sv
hdl/bsc_store.sv
hdl/bankers_safety_check.sv
hdl/bsc_checker.sv
dv/bsc_sequence_checker.sv
dv/tb.sv
